@@ rtl/assert_macros.svh @@
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle port assertion failed");

// Next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle port assertion failed");

`endif

@@ rtl/bfr_pkg.sv @@
// Types, constants and codes of the buffer frame replacement block
`timescale 1ns / 1ps

package bfr_pkg;

   localparam int FRAMES    = 8;
   localparam int FRAME_W   = $clog2(FRAMES);
   localparam int POS_W     = $clog2(FRAMES + 1);
   localparam int PAGE_W    = 24;
   localparam int PIN_W     = 8;
   localparam int CNT_W     = 32;
   localparam int OP_W      = 3;
   localparam int STATUS_W  = 2;
   localparam int MAX_RES   = 8;
   localparam int RES_W     = $clog2(MAX_RES + 1);
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [OP_W-1:0] OP_PIN   = 3'd0;
   localparam logic [OP_W-1:0] OP_UNPIN = 3'd1;
   localparam logic [OP_W-1:0] OP_DIRTY = 3'd2;
   localparam logic [OP_W-1:0] OP_FORCE = 3'd3;
   localparam logic [OP_W-1:0] OP_FLUSH = 3'd4;

   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_MISS   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_PINNED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_POOL   = 1'b1;

   localparam logic POLICY_LRU = 1'b1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_FIND,
      S_VICTIM,
      S_FLUSH
   } state_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [PAGE_W-1:0] page;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                hit;
      logic [FRAME_W-1:0]  frame_index;
      logic                fetch_valid;
      logic                writeback_valid;
      logic [PAGE_W-1:0]   writeback_page;
      logic [CNT_W-1:0]    read_count;
      logic [CNT_W-1:0]    write_count;
      logic                last;
   } rsp_type;

   // Order list update: append a new frame or move one position to the tail
   typedef struct packed {
      logic               append;
      logic               move;
      logic [FRAME_W-1:0] pos;
   } order_cmd_type;

endpackage

@@ rtl/bfr_order.sv @@
// Replacement order list: frame indices head first, append and move-to-tail
`timescale 1ns / 1ps

module bfr_order (
   input  logic                         clock,
   input  bfr_pkg::order_cmd_type       cmd,
   input  logic [bfr_pkg::POS_W-1:0]    frames_used,
   input  logic [bfr_pkg::FRAME_W-1:0]  rd_pos,
   output logic [bfr_pkg::FRAME_W-1:0]  rd_frame
);
   import bfr_pkg::*;

   logic [FRAME_W-1:0] order_ff [FRAMES];
   logic [FRAME_W-1:0] order_in [FRAMES];
   logic [POS_W-1:0]   tail;

   assign tail     = frames_used - POS_W'(1);
   assign rd_frame = order_ff[rd_pos];

   always_comb begin
      order_in = order_ff;
      if (cmd.append) begin
         // new frame index equals its position
         order_in[cmd.pos] = cmd.pos;
      end
      if (cmd.move) begin
         for (int i = 0; i < FRAMES; i++) begin
            if (POS_W'(i) >= POS_W'(cmd.pos) && POS_W'(i) + POS_W'(1) < frames_used) begin
               order_in[i] = order_ff[(i + 1) % FRAMES];
            end
         end
         order_in[tail[FRAME_W-1:0]] = order_ff[cmd.pos];
      end
   end

   always_ff @(posedge clock) begin
      order_ff <= order_in;
   end

endmodule

@@ rtl/buffer_frame_replacement.sv @@
// Top level: buffer frame table with FIFO / LRU replacement and its sequencer
`timescale 1ns / 1ps

// Usage
//   Request channel: drive req_data and raise start; the transaction is taken
//   at the rising edge where start is high and busy is low. busy stays high
//   while the sequencer works on it; no new transaction is taken meanwhile.
//   Result channel: each result sits on rsp_data for exactly one cycle with
//   rsp_valid high; rsp_data.last marks the final result of a transaction.
//   The receiver cannot stall: sample every cycle rsp_valid is high.
//   Configuration: csr_we with csr_index/csr_wdata writes policy (index 0)
//   or pool_size (index 1) at the clock edge; write only while idle.
// Timing
//   One shared scan walks the order list, one position a cycle.
//   Pin/unpin/dirty/force: the walk stops at the matching position, or after
//   an end check past the last frame in use when the page is absent.
//   A pin miss that must evict walks the list a second time for the first
//   unpinned frame. Flush walks every frame in use, one result per dirty
//   unpinned frame, or one empty result if none. An unknown op answers in
//   the next cycle without going busy. The final result appears in the
//   cycle that busy falls.
// Reset
//   Synchronous, active high: table empty, counters zero, FIFO, pool 8.

module buffer_frame_replacement (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  bfr_pkg::req_type                req_data,
   output logic                            rsp_valid,
   output bfr_pkg::rsp_type                rsp_data,
   input  logic                            csr_we,
   input  logic [bfr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bfr_pkg::CFG_W-1:0]       csr_wdata
);
   import bfr_pkg::*;

   localparam logic [PIN_W-1:0] PIN_MAX = '1;

   // sequencer
   state_type            state_ff, state_in;
   logic [OP_W-1:0]      op_ff, op_in;
   logic [PAGE_W-1:0]    page_ff, page_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [RES_W-1:0]     nres_ff, nres_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_type              pend_ff, pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // configuration
   logic                 policy_ff;
   logic [CFG_W-1:0]     pool_ff;

   // frame table and counters
   logic [POS_W-1:0]     used_ff, used_in;
   logic [CNT_W-1:0]     reads_ff, reads_in;
   logic [CNT_W-1:0]     writes_ff, writes_in;
   logic [PAGE_W-1:0]    page_mem_ff [FRAMES];
   logic [PAGE_W-1:0]    page_mem_in [FRAMES];
   logic [PIN_W-1:0]     pins_ff [FRAMES];
   logic [PIN_W-1:0]     pins_in [FRAMES];
   logic                 dirty_ff [FRAMES];
   logic                 dirty_in [FRAMES];

   // shared scan unit
   order_cmd_type        ocmd;
   logic [FRAME_W-1:0]   cur_frame;
   logic [FRAME_W-1:0]   new_frame;
   logic [POS_W-1:0]     cap;
   logic                 scan_end;
   logic                 page_match;
   logic                 cur_unpinned;
   logic                 room;
   logic                 flush_done;

   function automatic rsp_type make_rsp(
      input logic [STATUS_W-1:0] status,
      input logic                hit,
      input logic [FRAME_W-1:0]  frame,
      input logic                fetch,
      input logic                wbv,
      input logic [PAGE_W-1:0]   wbp,
      input logic [CNT_W-1:0]    rc,
      input logic [CNT_W-1:0]    wc,
      input logic                last
   );
      rsp_type r;
      r.status          = status;
      r.hit             = hit;
      r.frame_index     = frame;
      r.fetch_valid     = fetch;
      r.writeback_valid = wbv;
      r.writeback_page  = wbp;
      r.read_count      = rc;
      r.write_count     = wc;
      r.last            = last;
      return r;
   endfunction

   bfr_order u_order (
      .clock       (clock),
      .cmd         (ocmd),
      .frames_used (used_ff),
      .rd_pos      (pos_ff[FRAME_W-1:0]),
      .rd_frame    (cur_frame)
   );

   // Capacity: zero counts as one, above the table size clamps to it
   always_comb begin
      if (pool_ff == '0) begin
         cap = POS_W'(1);
      end else if (POS_W'(pool_ff) > POS_W'(FRAMES)) begin
         cap = POS_W'(FRAMES);
      end else begin
         cap = POS_W'(pool_ff);
      end
   end

   assign scan_end     = (pos_ff >= used_ff);
   assign page_match   = (page_mem_ff[cur_frame] == page_ff);
   assign cur_unpinned = (pins_ff[cur_frame] == '0);
   assign room         = (used_ff < cap);
   assign new_frame    = used_ff[FRAME_W-1:0];
   assign flush_done   = scan_end || (nres_ff == RES_W'(MAX_RES));
   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_data.op == OP_FLUSH) begin
                  state_in = S_FLUSH;
               end else if (req_data.op inside {OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE}) begin
                  state_in = S_FIND;
               end
            end
         end
         S_FIND: begin
            if (scan_end) begin
               state_in = (op_ff == OP_PIN && !room) ? S_VICTIM : S_IDLE;
            end else if (page_match) begin
               state_in = S_IDLE;
            end
         end
         S_VICTIM: begin
            if (scan_end || cur_unpinned) begin
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (flush_done) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath actions and result
   always_comb begin
      op_in         = op_ff;
      page_in       = page_ff;
      pos_in        = pos_ff;
      nres_in       = nres_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      used_in       = used_ff;
      reads_in      = reads_ff;
      writes_in     = writes_ff;
      page_mem_in   = page_mem_ff;
      pins_in       = pins_ff;
      dirty_in      = dirty_ff;
      ocmd          = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in         = req_data.op;
               page_in       = req_data.page;
               pos_in        = '0;
               nres_in       = '0;
               pend_valid_in = 1'b0;
               // unknown op: answer at once
               if (!(req_data.op inside {OP_PIN, OP_UNPIN, OP_DIRTY, OP_FORCE, OP_FLUSH})) begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(STAT_MISS, 1'b0, '0, 1'b0, 1'b0, '0,
                                    reads_ff, writes_ff, 1'b1);
               end
            end
         end

         S_FIND: begin
            if (scan_end) begin
               if (op_ff == OP_PIN) begin
                  if (room) begin
                     // take a fresh frame at the tail
                     ocmd.append            = 1'b1;
                     ocmd.pos               = new_frame;
                     used_in                = used_ff + POS_W'(1);
                     page_mem_in[new_frame] = page_ff;
                     pins_in[new_frame]     = PIN_W'(1);
                     dirty_in[new_frame]    = 1'b0;
                     reads_in               = reads_ff + CNT_W'(1);
                     rsp_valid_in           = 1'b1;
                     rsp_in = make_rsp(STAT_OK, 1'b0, new_frame, 1'b1, 1'b0, '0,
                                       reads_ff + CNT_W'(1), writes_ff, 1'b1);
                  end else begin
                     // restart the walk for a victim
                     pos_in = '0;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in = make_rsp(STAT_MISS, 1'b0, '0, 1'b0, 1'b0, '0,
                                    reads_ff, writes_ff, 1'b1);
               end
            end else if (page_match) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(STAT_OK, 1'b0, cur_frame, 1'b0, 1'b0, '0,
                                 reads_ff, writes_ff, 1'b1);
               case (op_ff)
                  OP_PIN: begin
                     if (pins_ff[cur_frame] != PIN_MAX) begin
                        pins_in[cur_frame] = pins_ff[cur_frame] + PIN_W'(1);
                     end
                     if (policy_ff == POLICY_LRU) begin
                        ocmd.move = 1'b1;
                        ocmd.pos  = pos_ff[FRAME_W-1:0];
                     end
                     rsp_in.hit = 1'b1;
                  end
                  OP_UNPIN: begin
                     if (pins_ff[cur_frame] != '0) begin
                        pins_in[cur_frame] = pins_ff[cur_frame] - PIN_W'(1);
                     end
                  end
                  OP_DIRTY: begin
                     dirty_in[cur_frame] = 1'b1;
                  end
                  OP_FORCE: begin
                     if (!dirty_ff[cur_frame]) begin
                        rsp_in.status = STAT_MISS;
                     end else begin
                        dirty_in[cur_frame] = 1'b0;
                        writes_in           = writes_ff + CNT_W'(1);
                        rsp_in = make_rsp(STAT_OK, 1'b0, cur_frame, 1'b0, 1'b1,
                                          page_mem_ff[cur_frame], reads_ff,
                                          writes_ff + CNT_W'(1), 1'b1);
                     end
                  end
                  default: begin
                     rsp_in.status = STAT_MISS;
                  end
               endcase
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end

         S_VICTIM: begin
            if (scan_end) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_rsp(STAT_PINNED, 1'b0, '0, 1'b0, 1'b0, '0,
                                 reads_ff, writes_ff, 1'b1);
            end else if (cur_unpinned) begin
               // evict: write back if dirty, reload, move to tail
               ocmd.move              = 1'b1;
               ocmd.pos               = pos_ff[FRAME_W-1:0];
               page_mem_in[cur_frame] = page_ff;
               pins_in[cur_frame]     = PIN_W'(1);
               dirty_in[cur_frame]    = 1'b0;
               reads_in               = reads_ff + CNT_W'(1);
               rsp_valid_in           = 1'b1;
               if (dirty_ff[cur_frame]) begin
                  writes_in = writes_ff + CNT_W'(1);
                  rsp_in = make_rsp(STAT_OK, 1'b0, cur_frame, 1'b1, 1'b1,
                                    page_mem_ff[cur_frame], reads_ff + CNT_W'(1),
                                    writes_ff + CNT_W'(1), 1'b1);
               end else begin
                  rsp_in = make_rsp(STAT_OK, 1'b0, cur_frame, 1'b1, 1'b0, '0,
                                    reads_ff + CNT_W'(1), writes_ff, 1'b1);
               end
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end

         S_FLUSH: begin
            if (flush_done) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in      = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = make_rsp(STAT_OK, 1'b0, '0, 1'b0, 1'b0, '0,
                                    reads_ff, writes_ff, 1'b1);
               end
               pend_valid_in = 1'b0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
               if (dirty_ff[cur_frame] && cur_unpinned) begin
                  // hold each write-back in pend until the next one or the end, so the final one gets last
                  dirty_in[cur_frame] = 1'b0;
                  writes_in           = writes_ff + CNT_W'(1);
                  nres_in             = nres_ff + RES_W'(1);
                  rsp_valid_in        = pend_valid_ff;
                  rsp_in              = pend_ff;
                  pend_valid_in       = 1'b1;
                  pend_in = make_rsp(STAT_OK, 1'b0, cur_frame, 1'b0, 1'b1,
                                     page_mem_ff[cur_frame], reads_ff,
                                     writes_ff + CNT_W'(1), 1'b0);
               end
            end
         end

         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         used_ff       <= '0;
         reads_ff      <= '0;
         writes_ff     <= '0;
         for (int i = 0; i < FRAMES; i++) begin
            pins_ff[i]  <= '0;
            dirty_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         used_ff       <= used_in;
         reads_ff      <= reads_in;
         writes_ff     <= writes_in;
         pins_ff       <= pins_in;
         dirty_ff      <= dirty_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= 1'b0;
         pool_ff   <= CFG_W'(FRAMES);
      end else if (csr_we) begin
         case (csr_index)
            CSR_POLICY: policy_ff <= csr_wdata[0];
            CSR_POOL:   pool_ff   <= csr_wdata;
            default:    policy_ff <= policy_ff;
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      page_ff     <= page_in;
      pos_ff      <= pos_in;
      nres_ff     <= nres_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
      page_mem_ff <= page_mem_in;
   end

endmodule

@@ rtl/bfr_checker.sv @@
// Port-level checker for the buffer frame replacement block, with its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           start,
   input logic                           busy,
   input bfr_pkg::req_type               req_data,
   input logic                           rsp_valid,
   input bfr_pkg::rsp_type               rsp_data,
   input logic                           csr_we,
   input logic [bfr_pkg::CSR_IDX_W-1:0]  csr_index,
   input logic [bfr_pkg::CFG_W-1:0]      csr_wdata
);
   import bfr_pkg::*;

   logic known_op;
   logic cfg_touch;
   logic final_rsp;
   logic fetch_shape;

   assign known_op  = (req_data.op == OP_PIN) || (req_data.op == OP_UNPIN) ||
                      (req_data.op == OP_DIRTY) || (req_data.op == OP_FORCE) ||
                      (req_data.op == OP_FLUSH);
   assign cfg_touch = csr_we && (csr_index == CSR_POOL) && (csr_wdata == '0);
   assign final_rsp   = rsp_valid && rsp_data.last;
   assign fetch_shape = (rsp_data.status == STAT_OK) && !rsp_data.hit && rsp_data.last;

   // the final result of a transaction shows in the cycle busy drops
   `ASSERT_IMPLIES(a_fell_busy_last, clock, reset, $fell(busy) && !cfg_touch, final_rsp)
   // a known op always occupies the sequencer
   `ASSERT_NEXT(a_known_op_busy, clock, reset, start && !busy && known_op, busy)
   // a non-final flush result leaves the block still busy
   `ASSERT_IMPLIES(a_more_results_busy, clock, reset, rsp_valid && !rsp_data.last, busy)
   // a fetch is a successful miss, closing its transaction
   `ASSERT_IMPLIES(a_fetch_shape, clock, reset, rsp_valid && rsp_data.fetch_valid, fetch_shape)

endmodule

bind buffer_frame_replacement bfr_checker u_bfr_checker (.*);
